/* src/pt_comp_pkg.sv */
// Shared types and constants for the pressure and temperature compensation pipeline.
// No dependencies; every other module in src imports this package.
`timescale 1ns / 1ps

package pt_comp_pkg;

  localparam int RAW_W  = 24;  // converter reading width
  localparam int CAL_W  = 16;  // calibration word width
  localparam int DT_W   = 25;  // temperature difference, signed
  localparam int PRD_W  = 42;  // dT times a calibration word, signed
  localparam int TEMP_W = 19;  // temperature in 0.01 C, signed
  localparam int OS_W   = 42;  // offset and sensitivity, signed
  localparam int SQ_W   = 38;  // square of a temperature difference, signed
  localparam int OUT_W  = 32;  // compensated pressure
  localparam int IDX_W  = 3;   // configuration register index

  localparam int TEMP_SHIFT = 23;
  localparam int OFF_DIV_SH = 6;
  localparam int SENS_DIV_SH = 7;
  localparam int OFF_SHIFT  = 17;
  localparam int SENS_SHIFT = 16;
  localparam int PROD_SHIFT = 21;
  localparam int FINAL_SHIFT = 15;
  localparam int SHI_W = OS_W - PROD_SHIFT;  // upper signed slice of sensitivity

  localparam logic signed [TEMP_W-1:0] TEMP_BASE  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT = 19'sd1500;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_C1 = 3'd0;
  localparam logic [IDX_W-1:0] REG_C2 = 3'd1;
  localparam logic [IDX_W-1:0] REG_C3 = 3'd2;
  localparam logic [IDX_W-1:0] REG_C4 = 3'd3;
  localparam logic [IDX_W-1:0] REG_C5 = 3'd4;
  localparam logic [IDX_W-1:0] REG_C6 = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order terms, handed from the base stages to the correction stages.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [OS_W-1:0]   off;
    logic signed [OS_W-1:0]   sens;
    logic [RAW_W-1:0]         rp;
  } base_t;

  // Corrected terms, handed to the pressure stages.
  typedef struct packed {
    logic signed [OS_W-1:0] off;
    logic signed [OS_W-1:0] sens;
    logic [RAW_W-1:0]       rp;
  } corr_t;

endpackage

/* src/pt_comp_base.sv */
// Stages one to three: temperature difference, the three dT products, and the
// first-order temperature, offset and sensitivity. Depends on pt_comp_pkg.
`timescale 1ns / 1ps

module pt_comp_base (
  input  logic                        clk,
  input  logic                        rst,
  input  pt_comp_pkg::cal_t           cal,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pt_comp_pkg::RAW_W-1:0] raw_temp,
  input  logic [pt_comp_pkg::RAW_W-1:0] raw_press,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pt_comp_pkg::base_t          out_data
);
  import pt_comp_pkg::*;

  logic [2:0] v;
  logic [2:0] rdy;

  logic signed [DT_W-1:0]  s1_dt;
  logic [RAW_W-1:0]        s1_rp;
  logic signed [PRD_W-1:0] s2_p6, s2_p4, s2_p3;
  logic [RAW_W-1:0]        s2_rp;
  base_t                   s3;

  logic signed [DT_W-1:0]  dt_next;
  logic signed [PRD_W-1:0] q6, q4, q3;

  assign rdy[2]   = !v[2] || out_ready;
  assign rdy[1]   = !v[1] || rdy[2];
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = v[2];
  assign out_data  = s3;

  assign dt_next = $signed({1'b0, raw_temp}) - $signed({1'b0, cal.c5, 8'h00});

  // Signed division by a power of two that truncates toward zero: bias negatives first.
  assign q6 = $signed(s2_p6 + (s2_p6[PRD_W-1] ? PRD_W'((64'd1 << TEMP_SHIFT) - 1) : '0))
              >>> TEMP_SHIFT;
  assign q4 = $signed(s2_p4 + (s2_p4[PRD_W-1] ? PRD_W'((64'd1 << OFF_DIV_SH) - 1) : '0))
              >>> OFF_DIV_SH;
  assign q3 = $signed(s2_p3 + (s2_p3[PRD_W-1] ? PRD_W'((64'd1 << SENS_DIV_SH) - 1) : '0))
              >>> SENS_DIV_SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
      if (rdy[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dt <= dt_next;
      s1_rp <= raw_press;
    end
    if (rdy[1]) begin
      s2_p6 <= PRD_W'(s1_dt * $signed({1'b0, cal.c6}));
      s2_p4 <= PRD_W'(s1_dt * $signed({1'b0, cal.c4}));
      s2_p3 <= PRD_W'(s1_dt * $signed({1'b0, cal.c3}));
      s2_rp <= s1_rp;
    end
    if (rdy[2]) begin
      s3.temp <= TEMP_BASE + q6[TEMP_W-1:0];
      s3.off  <= $signed({{(OS_W-CAL_W-OFF_SHIFT){1'b0}}, cal.c2, {OFF_SHIFT{1'b0}}})
                 + OS_W'(q4);
      s3.sens <= $signed({{(OS_W-CAL_W-SENS_SHIFT){1'b0}}, cal.c1, {SENS_SHIFT{1'b0}}})
                 + OS_W'(q3);
      s3.rp   <= s2_rp;
    end
  end

endmodule

/* src/pt_comp_corr.sv */
// Stages four and five: squares of the temperature deviations and the
// low-temperature corrections of offset and sensitivity. Depends on pt_comp_pkg.
`timescale 1ns / 1ps

module pt_comp_corr (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pt_comp_pkg::base_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pt_comp_pkg::corr_t out_data
);
  import pt_comp_pkg::*;

  logic [1:0] v;
  logic [1:0] rdy;

  logic signed [SQ_W-1:0] s4_sq, s4_sq2;
  logic                   s4_cold, s4_vcold;
  logic signed [OS_W-1:0] s4_off, s4_sens;
  logic [RAW_W-1:0]       s4_rp;
  corr_t                  s5;

  logic signed [TEMP_W-1:0] d, e;
  logic signed [OS_W-1:0]   sq_w, sq2_w, off_c, sens_c;

  assign rdy[1]   = !v[1] || out_ready;
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = v[1];
  assign out_data  = s5;

  assign d = in_data.temp - TEMP_BASE;
  assign e = in_data.temp + COLD_LIMIT;

  // Both squares are non-negative, so the halving and quartering are plain shifts.
  assign sq_w  = OS_W'(s4_sq);
  assign sq2_w = OS_W'(s4_sq2);

  always_comb begin
    off_c  = '0;
    sens_c = '0;
    if (s4_cold) begin
      off_c  = ((sq_w <<< 2) + sq_w) >>> 1;
      sens_c = ((sq_w <<< 2) + sq_w) >>> 2;
      if (s4_vcold) begin
        off_c  = off_c + (sq2_w <<< 3) - sq2_w;
        sens_c = sens_c + (((sq2_w <<< 3) + (sq2_w <<< 1) + sq2_w) >>> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s4_sq    <= SQ_W'(d * d);
      s4_sq2   <= SQ_W'(e * e);
      s4_cold  <= in_data.temp < TEMP_BASE;
      s4_vcold <= in_data.temp < -COLD_LIMIT;
      s4_off   <= in_data.off;
      s4_sens  <= in_data.sens;
      s4_rp    <= in_data.rp;
    end
    if (rdy[1]) begin
      s5.off  <= s4_off - off_c;
      s5.sens <= s4_sens - sens_c;
      s5.rp   <= s4_rp;
    end
  end

endmodule

/* src/pt_comp_press.sv */
// Stages six and seven: raw pressure times sensitivity as two partial products,
// then the offset and the final scaling into the output register. Depends on pt_comp_pkg.
`timescale 1ns / 1ps

module pt_comp_press (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pt_comp_pkg::corr_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pt_comp_pkg::OUT_W-1:0] pressure
);
  import pt_comp_pkg::*;

  localparam int PH_W = RAW_W + 1 + SHI_W;
  localparam int PL_W = RAW_W + PROD_SHIFT;
  localparam int T_W  = PH_W + 2;

  logic [1:0] v;
  logic [1:0] rdy;

  logic signed [PH_W-1:0] s6_ph;
  logic [PL_W-1:0]        s6_pl;
  logic signed [OS_W-1:0] s6_off;
  logic [OUT_W-1:0]       s7_p;

  logic signed [SHI_W-1:0] sens_hi;
  logic [PROD_SHIFT-1:0]   sens_lo;
  logic signed [T_W-1:0]   t;

  assign rdy[1]   = !v[1] || out_ready;
  assign rdy[0]   = !v[0] || rdy[1];
  assign in_ready = rdy[0];
  assign out_valid = v[1];
  assign pressure  = s7_p;

  // sens = sens_hi * 2^21 + sens_lo with sens_lo unsigned, so the floor of
  // rp * sens / 2^21 is rp * sens_hi plus the floor of rp * sens_lo / 2^21.
  assign sens_hi = in_data.sens[OS_W-1:PROD_SHIFT];
  assign sens_lo = in_data.sens[PROD_SHIFT-1:0];

  assign t = T_W'(s6_ph) + $signed({{(T_W-PL_W+PROD_SHIFT){1'b0}}, s6_pl[PL_W-1:PROD_SHIFT]})
             - T_W'(s6_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      if (rdy[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s6_ph  <= PH_W'($signed({1'b0, in_data.rp}) * sens_hi);
      s6_pl  <= PL_W'(in_data.rp * sens_lo);
      s6_off <= in_data.off;
    end
    if (rdy[1]) begin
      s7_p <= t[FINAL_SHIFT+OUT_W-1:FINAL_SHIFT];
    end
  end

endmodule

/* src/pressure_temperature_compensation.sv */
// Barometric pressure compensation with second-order low-temperature correction.
// Throughput: one request per cycle while out_ready stays high; seven pipeline stages,
// three 25x17 multipliers, two 19x19 squarers and a 25x21 and a 24x21 partial product
// set the depth. Reset (rst, synchronous, active high) empties the pipeline and clears
// all six calibration registers to zero. Depends on pt_comp_pkg and the three stage modules.
`timescale 1ns / 1ps

module pressure_temperature_compensation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pt_comp_pkg::IDX_W-1:0] cfg_index,
  input  logic [pt_comp_pkg::CAL_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pt_comp_pkg::RAW_W-1:0] raw_temp,
  input  logic [pt_comp_pkg::RAW_W-1:0] raw_press,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pt_comp_pkg::OUT_W-1:0] pressure_centi_mbar
);
  import pt_comp_pkg::*;

  cal_t  cal;
  base_t base_data;
  corr_t corr_data;
  logic  base_valid, base_ready;
  logic  corr_valid, corr_ready;
  logic [OUT_W-1:0] pressure;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_C1:  cal.c1 <= cfg_data;
        REG_C2:  cal.c2 <= cfg_data;
        REG_C3:  cal.c3 <= cfg_data;
        REG_C4:  cal.c4 <= cfg_data;
        REG_C5:  cal.c5 <= cfg_data;
        REG_C6:  cal.c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  pt_comp_base u_base (
    .clk       (clk),
    .rst       (rst),
    .cal       (cal),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_temp  (raw_temp),
    .raw_press (raw_press),
    .out_valid (base_valid),
    .out_ready (base_ready),
    .out_data  (base_data)
  );

  pt_comp_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (base_valid),
    .in_ready  (base_ready),
    .in_data   (base_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  pt_comp_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pressure  (pressure)
  );

  assign pressure_centi_mbar = $signed(pressure);

endmodule

/* src/pt_comp_check.sv */
// Port-level checker for the pressure compensation block, bound to the top level.
// Depends on pt_comp_pkg for field widths.
`timescale 1ns / 1ps

module pt_comp_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [pt_comp_pkg::RAW_W-1:0] raw_temp,
  input logic [pt_comp_pkg::RAW_W-1:0] raw_press,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [pt_comp_pkg::OUT_W-1:0] pressure_centi_mbar
);
  import pt_comp_pkg::*;

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // With no result waiting, nothing downstream can hold back a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused while the output is empty");

  // A request accepted while the output never stalls appears once it has passed every pipeline stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    ($past(in_valid && in_ready && !rst, 7) &&
     $past(out_ready && !rst, 1) && $past(out_ready && !rst, 2) &&
     $past(out_ready && !rst, 3) && $past(out_ready && !rst, 4) &&
     $past(out_ready && !rst, 5) && $past(out_ready && !rst, 6)) |-> out_valid)
    else $error("result missing after the pipeline latency");

  // A waiting request keeps its readings until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(raw_temp) && $stable(raw_press))
    else $error("waiting request changed or dropped");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_centi_mbar))
    else $error("stalled result changed or dropped");

endmodule

bind pressure_temperature_compensation pt_comp_check u_pt_comp_check (.*);

/* verif/pressure_checker.sv */
// Checker for the pressure compensation block: watches the request and result channels and the config port,
// predicts each compensated pressure and compares it with the block's result.
// Depends on pt_comp_pkg for widths, register indexes and the calibration struct.
`timescale 1ns / 1ps

module pressure_checker
  import pt_comp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CAL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [RAW_W-1:0]        raw_temp,
  input  logic [RAW_W-1:0]        raw_press,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OUT_W-1:0] pressure_centi_mbar,
  output int                      errors,
  output int                      pending
);

  localparam longint TEMP_BASE_L  = 2000;
  localparam longint COLD_LIMIT_L = 1500;
  localparam longint TEMP_DIV     = longint'(1) << TEMP_SHIFT;
  localparam longint OFF_DIV      = longint'(1) << OFF_DIV_SH;
  localparam longint SENS_DIV     = longint'(1) << SENS_DIV_SH;

  cal_t                    cal;
  logic signed [OUT_W-1:0] expected_pressure[$];
  logic signed [OUT_W-1:0] want;

  function automatic logic signed [OUT_W-1:0] compensate_pressure(
    input cal_t w, input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp);
    longint rt_l, rp_l, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, d, e, off_c, sens_c, p;
    rt_l = rt;
    rp_l = rp;
    c1 = w.c1;
    c2 = w.c2;
    c3 = w.c3;
    c4 = w.c4;
    c5 = w.c5;
    c6 = w.c6;
    dt   = rt_l - c5 * 256;
    temp = TEMP_BASE_L + (dt * c6) / TEMP_DIV;
    off  = (c2 << OFF_SHIFT) + (c4 * dt) / OFF_DIV;
    sens = (c1 << SENS_SHIFT) + (c3 * dt) / SENS_DIV;
    // Second-order correction below 20.00 C, with an extra term below -15.00 C.
    if (temp < TEMP_BASE_L) begin
      d = temp - TEMP_BASE_L;
      off_c  = (5 * d * d) / 2;
      sens_c = (5 * d * d) / 4;
      if (temp < -COLD_LIMIT_L) begin
        e = temp + COLD_LIMIT_L;
        off_c  = off_c + 7 * e * e;
        sens_c = sens_c + (11 * e * e) / 2;
      end
      off  = off - off_c;
      sens = sens - sens_c;
    end
    p = (((rp_l * sens) >>> PROD_SHIFT) - off) >>> FINAL_SHIFT;
    return p[OUT_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cal <= '0;
      expected_pressure.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      // A request sees the calibration in force before any write at the same edge.
      if (in_valid && in_ready)
        expected_pressure.push_back(compensate_pressure(cal, raw_temp, raw_press));
      if (out_valid && out_ready) begin
        if (expected_pressure.size() == 0) begin
          $error("pressure_centi_mbar: expected nothing, got %0d", pressure_centi_mbar);
          errors <= errors + 1;
        end else begin
          want = expected_pressure.pop_front();
          if (pressure_centi_mbar !== want) begin
            $error("pressure_centi_mbar: expected %0d, got %0d", want, pressure_centi_mbar);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_C1: cal.c1 <= cfg_data;
          REG_C2: cal.c2 <= cfg_data;
          REG_C3: cal.c3 <= cfg_data;
          REG_C4: cal.c4 <= cfg_data;
          REG_C5: cal.c5 <= cfg_data;
          REG_C6: cal.c6 <= cfg_data;
          default: ;
        endcase
      end
      pending <= expected_pressure.size();
    end
  end

endmodule

/* verif/pressure_temperature_compensation_tb.sv */
// Top of the pressure compensation testbench: clock, reset, calibration writes and request stimulus.
// Depends on pt_comp_pkg, the pressure_temperature_compensation block and pressure_checker.
`timescale 1ns / 1ps

module pressure_temperature_compensation_tb;
  import pt_comp_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int LIMIT        = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 100;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [RAW_W-1:0] RAW_MAX   = '1;
  localparam logic [RAW_W-1:0] TYP_PRESS = 24'd6465444;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CAL_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_ready;
  logic [RAW_W-1:0]        raw_temp  = '0;
  logic [RAW_W-1:0]        raw_press = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic signed [OUT_W-1:0] pressure_centi_mbar;

  logic idle_on     = 1'b1;
  int   stall_left  = 0;
  int   cycle_count = 0;
  int   errors;
  int   pending;

  pressure_temperature_compensation dut (.*);
  pressure_checker checker_i (.*);

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver side: random stall bursts begin only while idle_on is set.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Starts and ends on a falling edge; leaves valid high so back-to-back requests need no gap.
  task automatic send_reading(input logic [RAW_W-1:0] t, input logic [RAW_W-1:0] p);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    raw_temp  <= t;
    raw_press <= p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    @(negedge clk);
  endtask

  task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic load_cal(input cal_t w);
    put_reg(REG_C1, w.c1);
    put_reg(REG_SPARE_LO, CAL_W'($urandom));
    put_reg(REG_C2, w.c2);
    put_reg(REG_C3, w.c3);
    put_reg(REG_C4, w.c4);
    put_reg(REG_C5, w.c5);
    put_reg(REG_C6, w.c6);
    put_reg(REG_SPARE_HI, CAL_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CAL_W-1:0] pick_word(input int mode);
    case (mode)
      1: return '1;
      2: return '0;
      3: return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return CAL_W'($urandom);
    endcase
  endfunction

  // Most picks land near or below the reference point so both cold corrections are reached.
  function automatic logic [RAW_W-1:0] pick_temp(input logic [CAL_W-1:0] c5);
    logic [RAW_W-1:0] base_raw;
    base_raw = {c5, 8'h00};
    case ($urandom_range(0, 3))
      0: return RAW_W'($urandom);
      1: return base_raw + RAW_W'($urandom_range(0, 8191)) - RAW_W'(4096);
      2: return base_raw + RAW_W'($urandom_range(0, 2097151)) - RAW_W'(1048576);
      default: return base_raw - RAW_W'($urandom_range(0, 8388607));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_press();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return RAW_MAX;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    cal_t setting;
    logic [RAW_W-1:0] base_raw;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // All calibration words still at zero.
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    drain();

    // Typical calibration: 20.00 C boundary, just below, warm, cold, very cold and extreme readings.
    setting = '{c1: 16'd40000, c2: 16'd36000, c3: 16'd23000, c4: 16'd23000,
                c5: 16'd33000, c6: 16'd28000};
    load_cal(setting);
    base_raw = {setting.c5, 8'h00};
    send_reading(base_raw, TYP_PRESS);
    send_reading(base_raw - RAW_W'(300), TYP_PRESS);
    send_reading(base_raw + RAW_W'(5000), TYP_PRESS);
    send_reading(base_raw - RAW_W'(2000000), TYP_PRESS);
    send_reading('0, TYP_PRESS);
    send_reading(RAW_MAX, TYP_PRESS);
    send_reading(base_raw, '0);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    drain();

    // Every word at its maximum.
    setting = '1;
    load_cal(setting);
    send_reading('0, RAW_MAX);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, '0);
    send_reading(RAW_MAX, '0);
    send_reading(24'h800000, 24'h800000);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      setting.c1 = pick_word(ph);
      setting.c2 = pick_word(ph);
      setting.c3 = pick_word(ph);
      setting.c4 = pick_word(ph);
      setting.c5 = pick_word(ph);
      setting.c6 = pick_word(ph);
      load_cal(setting);
      if (ph == PHASES - 1)
        idle_on <= 1'b0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off once mid-phase until every outstanding request has its result.
        if (ph == 4 && k == PHASE_ITEMS / 2)
          drain();
        send_reading(pick_temp(setting.c5), pick_press());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
